// File: sv/wav_header_parse_and_gain_assert.svh
// Assertion helpers for the RTL of the WAV header parser.
`ifndef WAV_HEADER_PARSE_AND_GAIN_ASSERT_SVH
`define WAV_HEADER_PARSE_AND_GAIN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WAVHP_ASSERT_SAME(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WAVHP_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: sv/wavhp_pkg.sv
package wavhp_pkg;

	localparam int GAIN_FRAC_BITS = 7;
	localparam int GAIN_W = 9;
	localparam int SAMPLE_W = 16;
	localparam int DATA_W = 136;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd128;

	// Tags held with byte 0 in the lowest bits.
	localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
	localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
	localparam logic [23:0] FMT_TAG = 24'h74_6D66;
	localparam logic [23:0] ATA_TAG = 24'h61_7461;
	localparam logic [7:0] DATA_FIRST = 8'h64;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_FRAME = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_RIFF = 2'd0,
		ERR_WAVE = 2'd1,
		ERR_FMT = 2'd2
	} err_t;

	typedef enum logic {
		CFG_GAIN = 1'b0,
		CFG_SWAP = 1'b1
	} cfg_idx_t;

	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_SCAN = 6'b000010,
		PH_ATA = 6'b000100,
		PH_SIZE = 6'b001000,
		PH_FRAMES = 6'b010000,
		PH_HALT = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0] error_code;
		logic [31:0] rate_hz;
		logic [15:0] channel_count;
		logic [15:0] sample_bits;
		logic [31:0] payload_bytes;
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} result_t;

endpackage

// File: sv/wavhp_scale.sv
module wavhp_scale #(
	parameter int FRAC_BITS = wavhp_pkg::GAIN_FRAC_BITS
) (
	input logic signed [wavhp_pkg::SAMPLE_W-1:0] raw,
	input logic [wavhp_pkg::GAIN_W-1:0] gain,
	output logic signed [wavhp_pkg::SAMPLE_W-1:0] scaled
);

	localparam int LIMIT = 2 << FRAC_BITS;
	localparam int PW = wavhp_pkg::SAMPLE_W + wavhp_pkg::GAIN_W + 1;
	localparam logic signed [PW-1:0] BIAS = PW'((1 << FRAC_BITS) - 1);
	localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
	localparam logic signed [PW-1:0] SAT_LO = -PW'(32768);

	logic [wavhp_pkg::GAIN_W-1:0] gain_eff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] adj;
	logic signed [PW-1:0] quot;

	always_comb begin
		gain_eff = (int'(gain) > LIMIT) ? wavhp_pkg::GAIN_W'(LIMIT) : gain;
		prod = PW'(raw) * $signed({1'b0, gain_eff});
		// Bias negative products so the arithmetic shift truncates toward zero.
		adj = prod[PW-1] ? (prod + BIAS) : prod;
		quot = adj >>> FRAC_BITS;
		if (quot > SAT_HI) begin
			scaled = 16'sh7FFF;
		end else if (quot < SAT_LO) begin
			scaled = 16'sh8000;
		end else begin
			scaled = quot[wavhp_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

// File: sv/wav_header_parse_and_gain.sv
// A result is registered onto m_tvalid at the edge that accepts the byte causing it.
// One byte per cycle while s_tready is high; parser decode and both scalers are combinational.
// The output register takes a new result while the old one is being taken, so s_tready
// stays high unless a result waits and m_tready is low.
// Reset (arst_n low) puts the parser in the header phase, sets gain to unity (128),
// clears channel swap and drops any pending result.
module wav_header_parse_and_gain #(
	parameter int GAIN_FRAC_BITS = wavhp_pkg::GAIN_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] file_byte
	input logic s_tuser, // [0] start_req
	output logic m_tvalid,
	input logic m_tready,
	// [1:0] error_code, [33:2] rate_hz, [49:34] channel_count, [65:50] sample_bits,
	// [97:66] payload_bytes, [113:98] left_out, [129:114] right_out, [135:130] zero
	output logic [wavhp_pkg::DATA_W-1:0] m_tdata,
	output logic [1:0] m_tuser, // [1:0] kind
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [wavhp_pkg::GAIN_W-1:0] cfg_data
);

	logic [wavhp_pkg::GAIN_W-1:0] gain_q;
	logic swap_q;

	wavhp_pkg::phase_t phase_q, phase_d;
	logic [5:0] pos_q, pos_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] chan_q, chan_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] size_q, size_d;
	logic match_q, match_d;
	logic [23:0] frame_q, frame_d;
	logic [1:0] fidx_q, fidx_d;

	logic s_acc;
	logic res_valid;
	wavhp_pkg::kind_t res_kind;
	wavhp_pkg::result_t res;
	logic m_valid_q;
	wavhp_pkg::kind_t kind_q;
	wavhp_pkg::result_t out_q;

	logic [7:0] b;
	logic [1:0] ata_p;
	logic tag_m;
	logic signed [15:0] first_s, second_s;

	assign b = s_tdata;
	assign cfg_ready = 1'b1;
	assign s_tready = !m_valid_q || m_tready;
	assign s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= wavhp_pkg::GAIN_RESET;
			swap_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				wavhp_pkg::CFG_GAIN: gain_q <= cfg_data;
				wavhp_pkg::CFG_SWAP: swap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	wavhp_scale #(.FRAC_BITS(GAIN_FRAC_BITS)) u_scale_first (
		.raw(frame_q[15:0]),
		.gain(gain_q),
		.scaled(first_s)
	);

	wavhp_scale #(.FRAC_BITS(GAIN_FRAC_BITS)) u_scale_second (
		.raw({b, frame_q[23:16]}),
		.gain(gain_q),
		.scaled(second_s)
	);

	always_comb begin
		// A start restarts the parser from cleared state on this very byte.
		if (s_tuser) begin
			phase_d = wavhp_pkg::PH_HEADER;
			pos_d = '0;
			rate_d = '0;
			chan_d = '0;
			bits_d = '0;
			size_d = '0;
			match_d = 1'b1;
			frame_d = '0;
			fidx_d = '0;
		end else begin
			phase_d = phase_q;
			pos_d = pos_q;
			rate_d = rate_q;
			chan_d = chan_q;
			bits_d = bits_q;
			size_d = size_q;
			match_d = match_q;
			frame_d = frame_q;
			fidx_d = fidx_q;
		end
		res_valid = 1'b0;
		res_kind = wavhp_pkg::KIND_HEADER;
		res = '0;
		tag_m = 1'b0;
		ata_p = (pos_d[1:0] == 2'd3) ? 2'd2 : pos_d[1:0];

		case (phase_d)
			wavhp_pkg::PH_HEADER: begin
				if (pos_d <= 6'd3) begin
					tag_m = (b == wavhp_pkg::RIFF_TAG[8*pos_d[1:0] +: 8]);
					match_d = (pos_d == 6'd0) ? tag_m : (match_d && tag_m);
					if (pos_d == 6'd3 && !match_d) begin
						res_valid = 1'b1;
						res_kind = wavhp_pkg::KIND_ERROR;
						res.error_code = wavhp_pkg::ERR_RIFF;
					end
				end else if (pos_d >= 6'd8 && pos_d <= 6'd11) begin
					tag_m = (b == wavhp_pkg::WAVE_TAG[8*pos_d[1:0] +: 8]);
					match_d = (pos_d == 6'd8) ? tag_m : (match_d && tag_m);
					if (pos_d == 6'd11 && !match_d) begin
						res_valid = 1'b1;
						res_kind = wavhp_pkg::KIND_ERROR;
						res.error_code = wavhp_pkg::ERR_WAVE;
					end
				end else if (pos_d >= 6'd12 && pos_d <= 6'd14) begin
					tag_m = (b == wavhp_pkg::FMT_TAG[8*pos_d[1:0] +: 8]);
					match_d = (pos_d == 6'd12) ? tag_m : (match_d && tag_m);
				end else if (pos_d == 6'd15) begin
					if (!match_d) begin
						res_valid = 1'b1;
						res_kind = wavhp_pkg::KIND_ERROR;
						res.error_code = wavhp_pkg::ERR_FMT;
					end
				end else if (pos_d == 6'd22 || pos_d == 6'd23) begin
					chan_d[8*pos_d[0] +: 8] = chan_d[8*pos_d[0] +: 8] | b;
				end else if (pos_d >= 6'd24 && pos_d <= 6'd27) begin
					rate_d[8*pos_d[1:0] +: 8] = rate_d[8*pos_d[1:0] +: 8] | b;
				end else if (pos_d == 6'd34 || pos_d == 6'd35) begin
					bits_d[8*pos_d[0] +: 8] = bits_d[8*pos_d[0] +: 8] | b;
				end
				if (res_valid) begin
					phase_d = wavhp_pkg::PH_HALT;
					pos_d = pos_d + 6'd1;
				end else if (pos_d == 6'd35) begin
					phase_d = wavhp_pkg::PH_SCAN;
					pos_d = '0;
				end else begin
					pos_d = pos_d + 6'd1;
				end
			end
			wavhp_pkg::PH_SCAN: begin
				if (b == wavhp_pkg::DATA_FIRST) begin
					phase_d = wavhp_pkg::PH_ATA;
					pos_d = '0;
				end
			end
			wavhp_pkg::PH_ATA: begin
				tag_m = (b == wavhp_pkg::ATA_TAG[8*ata_p +: 8]);
				match_d = (ata_p == 2'd0) ? tag_m : (match_d && tag_m);
				if (ata_p == 2'd2) begin
					pos_d = '0;
					phase_d = match_d ? wavhp_pkg::PH_SIZE : wavhp_pkg::PH_SCAN;
				end else begin
					pos_d = {4'd0, ata_p} + 6'd1;
				end
			end
			wavhp_pkg::PH_SIZE: begin
				size_d[8*pos_d[1:0] +: 8] = size_d[8*pos_d[1:0] +: 8] | b;
				if (pos_d[1:0] == 2'd3) begin
					pos_d = '0;
					phase_d = wavhp_pkg::PH_FRAMES;
					frame_d = '0;
					fidx_d = '0;
					res_valid = 1'b1;
					res_kind = wavhp_pkg::KIND_HEADER;
					res.rate_hz = rate_d;
					res.channel_count = chan_d;
					res.sample_bits = bits_d;
					res.payload_bytes = size_d;
				end else begin
					pos_d = {4'd0, pos_d[1:0]} + 6'd1;
				end
			end
			wavhp_pkg::PH_FRAMES: begin
				// The scalers read the three held bytes from frame_q, which clears on the last byte.
				if (fidx_d != 2'd3) begin
					frame_d[8*fidx_d +: 8] = frame_d[8*fidx_d +: 8] | b;
					fidx_d = fidx_d + 2'd1;
				end else begin
					res_valid = 1'b1;
					res_kind = wavhp_pkg::KIND_FRAME;
					res.left_out = swap_q ? second_s : first_s;
					res.right_out = swap_q ? first_s : second_s;
					fidx_d = '0;
				end
			end
			wavhp_pkg::PH_HALT: ;
			default: ;
		endcase
	end

	// Frame bytes clear when a frame completes; done here so the scalers see the full word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wavhp_pkg::PH_HEADER;
			pos_q <= '0;
			rate_q <= '0;
			chan_q <= '0;
			bits_q <= '0;
			size_q <= '0;
			match_q <= 1'b1;
			frame_q <= '0;
			fidx_q <= '0;
		end else if (s_acc) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			rate_q <= rate_d;
			chan_q <= chan_d;
			bits_q <= bits_d;
			size_q <= size_d;
			match_q <= match_d;
			frame_q <= (res_valid && res_kind == wavhp_pkg::KIND_FRAME) ? '0 : frame_d;
			fidx_q <= fidx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_acc) begin
			m_valid_q <= res_valid;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && res_valid) begin
			kind_q <= res_kind;
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser = kind_q;
	assign m_tdata = {6'd0, out_q.right_out, out_q.left_out, out_q.payload_bytes,
		out_q.sample_bits, out_q.channel_count, out_q.rate_hz, out_q.error_code};

`include "wav_header_parse_and_gain_assert.svh"

	`WAVHP_ASSERT_NEXT(a_error_halts, clk, arst_n,
		s_acc && res_valid && res_kind == wavhp_pkg::KIND_ERROR,
		phase_q == wavhp_pkg::PH_HALT)

	`WAVHP_ASSERT_SAME(a_fidx_in_frames, clk, arst_n,
		fidx_q != 2'd0, phase_q == wavhp_pkg::PH_FRAMES)

	`WAVHP_ASSERT_SAME(a_frame_no_header, clk, arst_n,
		m_tvalid && m_tuser == wavhp_pkg::KIND_FRAME,
		m_tdata[97:0] == 98'd0)

endmodule

// File: tb/tb_wav_header_parse_and_gain.sv
module tb_wav_header_parse_and_gain;
	timeunit 1ns;
	timeprecision 1ps;

	import wavhp_pkg::*;

	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam int MAX_PRINTED = 40;

	// Expected output of one request: the kind travels in tuser, the rest in tdata.
	typedef struct packed {
		kind_t kind;
		result_t f;
	} wav_out_t;

	// One row of the directed part; rows with typed set carry their own error code.
	typedef struct packed {
		logic [7:0] b;
		logic st;
		logic typed;
		err_t err;
	} dir_row_t;

	localparam int DIR_ROWS = 22;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// Bytes right after reset with no start flag form a file of their own.
		'{"R", 1'b0, 1'b0, ERR_RIFF},
		'{"I", 1'b0, 1'b0, ERR_RIFF},
		'{"F", 1'b0, 1'b0, ERR_RIFF},
		'{"X", 1'b0, 1'b1, ERR_RIFF},
		// Ignored until the next start.
		'{8'hFF, 1'b0, 1'b0, ERR_RIFF},
		'{8'h00, 1'b0, 1'b0, ERR_RIFF},
		'{"R", 1'b1, 1'b0, ERR_RIFF},
		'{"I", 1'b0, 1'b0, ERR_RIFF},
		'{"F", 1'b0, 1'b0, ERR_RIFF},
		'{"F", 1'b0, 1'b0, ERR_RIFF},
		'{8'h00, 1'b0, 1'b0, ERR_RIFF},
		'{8'hFF, 1'b0, 1'b0, ERR_RIFF},
		'{8'h00, 1'b0, 1'b0, ERR_RIFF},
		'{8'hFF, 1'b0, 1'b0, ERR_RIFF},
		'{"W", 1'b0, 1'b0, ERR_RIFF},
		'{"A", 1'b0, 1'b0, ERR_RIFF},
		'{"V", 1'b0, 1'b0, ERR_RIFF},
		'{"F", 1'b0, 1'b1, ERR_WAVE},
		// A wrong first byte must fail the tag even when the rest matches.
		'{"Q", 1'b1, 1'b0, ERR_RIFF},
		'{"I", 1'b0, 1'b0, ERR_RIFF},
		'{"F", 1'b0, 1'b0, ERR_RIFF},
		'{"F", 1'b0, 1'b1, ERR_RIFF}
	};

	logic [8:0] gain_plan [PHASES] = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd128, 9'd255, 9'd384,
		9'd300};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = CFG_GAIN;
	logic [GAIN_W-1:0] cfg_data = '0;

	// Testbench-only side band that travels with each byte request.
	logic item_typed = 1'b0;
	err_t item_err = ERR_RIFF;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	wav_out_t pending_results[$];
	logic [7:0] stim_byte[$];
	logic stim_start[$];

	// Parser and gain state of the predictor.
	phase_t prs_phase;
	int prs_pos;
	logic [31:0] prs_rate;
	logic [15:0] prs_chans;
	logic [15:0] prs_bits;
	logic [31:0] prs_size;
	logic prs_match;
	logic [23:0] prs_fbytes;
	int prs_fidx;
	logic [GAIN_W-1:0] prs_gain;
	logic prs_swap;

	wav_header_parse_and_gain u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic clear_parser();
		prs_phase = PH_HEADER;
		prs_pos = 0;
		prs_rate = '0;
		prs_chans = '0;
		prs_bits = '0;
		prs_size = '0;
		prs_match = 1'b1;
		prs_fbytes = '0;
		prs_fidx = 0;
	endtask

	function automatic logic [15:0] scaled(logic [15:0] raw);
		int g;
		int s;
		int q;
		g = int'(prs_gain);
		if (g > (2 << GAIN_FRAC_BITS)) g = 2 << GAIN_FRAC_BITS;
		s = $signed(raw);
		// Integer division truncates toward zero, as the block does.
		q = (s * g) / (1 << GAIN_FRAC_BITS);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	task automatic flag_error(input err_t code, output logic has, inout wav_out_t r);
		has = 1'b1;
		r.kind = KIND_ERROR;
		r.f.error_code = code;
		prs_phase = PH_HALT;
	endtask

	task automatic parse_and_scale(input logic [7:0] b, input logic st, output logic has,
		output wav_out_t r);
		int p;
		logic m;
		logic [31:0] full;
		has = 1'b0;
		r = '0;
		if (st) clear_parser();
		case (prs_phase)
		PH_HEADER: begin
			p = prs_pos;
			prs_pos = p + 1;
			if (p <= 3) begin
				m = (b == RIFF_TAG[8*p +: 8]);
				prs_match = (p == 0) ? m : (prs_match && m);
				if (p == 3 && !prs_match) flag_error(ERR_RIFF, has, r);
			end else if (p >= 8 && p <= 11) begin
				m = (b == WAVE_TAG[8*(p-8) +: 8]);
				prs_match = (p == 8) ? m : (prs_match && m);
				if (p == 11 && !prs_match) flag_error(ERR_WAVE, has, r);
			end else if (p >= 12 && p <= 14) begin
				m = (b == FMT_TAG[8*(p-12) +: 8]);
				prs_match = (p == 12) ? m : (prs_match && m);
			end else if (p == 15) begin
				// The fmt tag is judged one byte after its third letter.
				if (!prs_match) flag_error(ERR_FMT, has, r);
			end else if (p == 22 || p == 23) begin
				prs_chans[8*(p-22) +: 8] = b;
			end else if (p >= 24 && p <= 27) begin
				prs_rate[8*(p-24) +: 8] = b;
			end else if (p == 34 || p == 35) begin
				prs_bits[8*(p-34) +: 8] = b;
				if (p == 35) begin
					prs_phase = PH_SCAN;
					prs_pos = 0;
				end
			end
		end
		PH_SCAN: begin
			if (b == DATA_FIRST) begin
				prs_phase = PH_ATA;
				prs_pos = 0;
			end
		end
		PH_ATA: begin
			p = prs_pos & 3;
			if (p > 2) p = 2;
			m = (b == ATA_TAG[8*p +: 8]);
			prs_match = (p == 0) ? m : (prs_match && m);
			prs_pos = p + 1;
			if (p == 2) begin
				prs_pos = 0;
				prs_phase = prs_match ? PH_SIZE : PH_SCAN;
			end
		end
		PH_SIZE: begin
			p = prs_pos & 3;
			prs_size[8*p +: 8] = b;
			prs_pos = p + 1;
			if (p == 3) begin
				prs_pos = 0;
				prs_phase = PH_FRAMES;
				prs_fbytes = '0;
				prs_fidx = 0;
				has = 1'b1;
				r.kind = KIND_HEADER;
				r.f.rate_hz = prs_rate;
				r.f.channel_count = prs_chans;
				r.f.sample_bits = prs_bits;
				r.f.payload_bytes = prs_size;
			end
		end
		PH_FRAMES: begin
			if (prs_fidx < 3) begin
				prs_fbytes[8*prs_fidx +: 8] = b;
				prs_fidx++;
			end else begin
				full = {b, prs_fbytes};
				prs_fbytes = '0;
				prs_fidx = 0;
				has = 1'b1;
				r.kind = KIND_FRAME;
				r.f.left_out = prs_swap ? scaled(full[31:16]) : scaled(full[15:0]);
				r.f.right_out = prs_swap ? scaled(full[15:0]) : scaled(full[31:16]);
			end
		end
		default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < MAX_PRINTED)
			$display("%0t mismatch on %s: got %h, wanted %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		wav_out_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unrequested result (kind)", 32'(m_tuser), 32'd0);
			return;
		end
		want = pending_results.pop_front();
		if (m_tuser != want.kind) report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
		if (m_tdata[1:0] != want.f.error_code)
			report_mismatch("error_code", 32'(m_tdata[1:0]), 32'(want.f.error_code));
		if (m_tdata[33:2] != want.f.rate_hz)
			report_mismatch("rate_hz", m_tdata[33:2], want.f.rate_hz);
		if (m_tdata[49:34] != want.f.channel_count)
			report_mismatch("channel_count", 32'(m_tdata[49:34]), 32'(want.f.channel_count));
		if (m_tdata[65:50] != want.f.sample_bits)
			report_mismatch("sample_bits", 32'(m_tdata[65:50]), 32'(want.f.sample_bits));
		if (m_tdata[97:66] != want.f.payload_bytes)
			report_mismatch("payload_bytes", m_tdata[97:66], want.f.payload_bytes);
		if (m_tdata[113:98] != want.f.left_out)
			report_mismatch("left_out", 32'(m_tdata[113:98]), 32'(want.f.left_out));
		if (m_tdata[129:114] != want.f.right_out)
			report_mismatch("right_out", 32'(m_tdata[129:114]), 32'(want.f.right_out));
	endtask

	// Outputs are checked before the byte of the same edge is predicted, so the order of
	// the queue never depends on the scheduling of processes.
	always @(posedge clk) begin : scoreboard
		logic has;
		wav_out_t pred;
		wav_out_t typed_out;
		if (!arst_n) begin
			prs_gain = GAIN_RESET;
			prs_swap = 1'b0;
			clear_parser();
		end else begin
			if (m_tvalid && m_tready) check_result();
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GAIN) prs_gain = cfg_data;
				else prs_swap = cfg_data[0];
			end
			if (s_tvalid && s_tready) begin
				parse_and_scale(s_tdata, s_tuser, has, pred);
				if (item_typed) begin
					typed_out = '0;
					typed_out.kind = KIND_ERROR;
					typed_out.f.error_code = item_err;
					pending_results.push_back(typed_out);
				end else if (has) begin
					pending_results.push_back(pred);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic st, input logic typed,
		input err_t err);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		item_typed <= typed;
		item_err <= err;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic configure(input logic [GAIN_W-1:0] g, input logic sw);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_GAIN;
		cfg_data <= g;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_SWAP;
		cfg_data <= {{(GAIN_W-1){1'b0}}, sw};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every predicted result has come out, then lets the clock run on.
	// The first edge lets the scoreboard record the request accepted at the current edge.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'h0000;
		3: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	// Builds one file: mostly well formed with random content, some truncated or broken.
	task automatic make_file();
		logic [7:0] fb[$];
		logic [7:0] r;
		logic [15:0] v16;
		logic [31:0] v32;
		int pick;
		int n;
		int k;
		int idx;
		int data_at;
		pick = $urandom_range(99);
		if (pick >= 94) begin
			n = $urandom_range(4, 20);
			repeat (n) begin
				stim_byte.push_back(8'($urandom));
				stim_start.push_back($urandom_range(7) == 0);
			end
			return;
		end
		for (k = 0; k < 4; k++) fb.push_back(RIFF_TAG[8*k +: 8]);
		repeat (4) fb.push_back(8'($urandom));
		for (k = 0; k < 4; k++) fb.push_back(WAVE_TAG[8*k +: 8]);
		for (k = 0; k < 3; k++) fb.push_back(FMT_TAG[8*k +: 8]);
		repeat (7) fb.push_back(8'($urandom));
		case ($urandom_range(3))
		0: v16 = 16'd2;
		1: v16 = 16'd1;
		2: v16 = 16'hFFFF;
		default: v16 = 16'($urandom);
		endcase
		fb.push_back(v16[7:0]);
		fb.push_back(v16[15:8]);
		case ($urandom_range(3))
		0: v32 = 32'd44100;
		1: v32 = 32'hFFFF_FFFF;
		2: v32 = 32'd0;
		default: v32 = $urandom;
		endcase
		for (k = 0; k < 4; k++) fb.push_back(v32[8*k +: 8]);
		repeat (6) fb.push_back(8'($urandom));
		v16 = ($urandom_range(1) == 0) ? 16'd16 : 16'($urandom);
		fb.push_back(v16[7:0]);
		fb.push_back(v16[15:8]);
		n = $urandom_range(0, 5);
		repeat (n) begin
			case ($urandom_range(9))
			6, 7: begin
				// A 'd' whose next three bytes fall one letter short of the chunk name.
				do r = 8'($urandom); while (r == ATA_TAG[23:16]);
				fb.push_back(DATA_FIRST);
				fb.push_back(ATA_TAG[7:0]);
				fb.push_back(ATA_TAG[15:8]);
				fb.push_back(r);
			end
			8: begin
				do r = 8'($urandom); while (r == ATA_TAG[7:0]);
				fb.push_back(DATA_FIRST);
				fb.push_back(r);
				fb.push_back(8'($urandom));
				fb.push_back(8'($urandom));
			end
			9: begin
				// The second 'd' is swallowed by the failed check, so no overlap match.
				fb.push_back(DATA_FIRST);
				fb.push_back(DATA_FIRST);
				for (k = 0; k < 3; k++) fb.push_back(ATA_TAG[8*k +: 8]);
			end
			default: begin
				do r = 8'($urandom); while (r == DATA_FIRST);
				fb.push_back(r);
			end
			endcase
		end
		data_at = fb.size();
		fb.push_back(DATA_FIRST);
		for (k = 0; k < 3; k++) fb.push_back(ATA_TAG[8*k +: 8]);
		case ($urandom_range(3))
		0: v32 = 32'd0;
		1: v32 = 32'hFFFF_FFFF;
		default: v32 = $urandom;
		endcase
		for (k = 0; k < 4; k++) fb.push_back(v32[8*k +: 8]);
		n = $urandom_range(0, 8);
		repeat (2 * n) begin
			v16 = pick_sample();
			fb.push_back(v16[7:0]);
			fb.push_back(v16[15:8]);
		end
		if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));

		if (pick >= 62 && pick < 88) begin
			if (pick < 70) begin
				n = $urandom_range(1, fb.size() - 1);
			end else begin
				if (pick < 76) idx = $urandom_range(0, 3);
				else if (pick < 82) idx = $urandom_range(8, 11);
				else idx = $urandom_range(12, 14);
				fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
				n = 16 + $urandom_range(0, 4);
			end
			while (fb.size() > n) void'(fb.pop_back());
		end else if (pick >= 88) begin
			fb[data_at + 2] = fb[data_at + 2] ^ 8'($urandom_range(1, 255));
		end
		for (k = 0; k < fb.size(); k++) begin
			stim_byte.push_back(fb[k]);
			stim_start.push_back(k == 0);
		end
	endtask

	initial begin
		int i;
		int ph;
		int mode;
		int sent;
		logic [GAIN_W-1:0] g;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].b, dir_rows[i].st, dir_rows[i].typed, dir_rows[i].err);

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			g = (ph == PHASES - 1) ? GAIN_W'($urandom_range(511)) : gain_plan[ph];
			configure(g, ph[0]);
			mode = ph % 4;
			tx_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 9 : 0;
			rx_stall_pct <= (mode == 2) ? 85 : (mode == 3) ? 9 : 0;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				make_file();
				while (stim_byte.size() != 0) begin
					// Long receiver hold while bytes keep coming, to back up the block.
					if (ph == 0 && sent == 20) hold_go <= ~hold_go;
					send_item(stim_byte.pop_front(), stim_start.pop_front(), 1'b0, ERR_RIFF);
					sent++;
				end
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
